/* hw/rtl/hsv_to_rgb_converter_core_defines.svh */
// assertion macros for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define H2R_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("h2r assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define H2R_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("h2r assertion failed: next-cycle check");

`endif

/* hw/rtl/h2r_pkg.sv */
// shared constants and types of the hsv to rgb converter
`default_nettype none

package h2r_pkg;

   localparam int HUE_BITS = 16;
   localparam int PCT_W    = 7;
   localparam int CH_W     = 8;
   localparam int SECTOR_W = 3;

   // products below 2^15 divided by 100 as a reciprocal multiply
   localparam int PROD_W      = 15;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_PW    = PROD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

   typedef struct packed {
      logic [CH_W-1:0]     hi;
      logic [CH_W-1:0]     lo;
      logic [SECTOR_W-1:0] sector;
      logic [HUE_BITS-1:0] frac;
   } h2r_mid_type;

endpackage

`default_nettype wire

/* hw/rtl/h2r_req_if.sv */
// input channel: hue, saturation and brightness
`default_nettype none

interface h2r_req_if;
   import h2r_pkg::*;

   logic                valid;
   logic                ready;
   logic [HUE_BITS-1:0] hue;
   logic [PCT_W-1:0]    saturation;
   logic [PCT_W-1:0]    brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

`default_nettype wire

/* hw/rtl/h2r_rsp_if.sv */
// result channel: red, green and blue
`default_nettype none

interface h2r_rsp_if;
   import h2r_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/h2r_front.sv */
// first three stages: channel maximum, minimum, hue sector and fraction
`default_nettype none

module h2r_front (
   input  wire logic          clock,
   input  wire logic          reset,
   h2r_req_if.sink            req_bus,
   output logic               mid_valid,
   input  wire logic          mid_ready,
   output h2r_pkg::h2r_mid_type mid_data
);
   import h2r_pkg::*;

   logic                  adv1, adv2, adv3;
   logic [PCT_W-1:0]      sat_c, val_c;
   logic [PROD_W-1:0]     val_x255;
   logic [RECIP_PW-1:0]   hi_full;
   logic [HUE_BITS+2:0]   six;
   logic [RECIP_PW-1:0]   lo_full;

   logic [CH_W-1:0]       s1_hi_in, s1_hi_ff;
   logic [PCT_W-1:0]      s1_inv_in, s1_inv_ff;
   logic [SECTOR_W-1:0]   s1_sector_in, s1_sector_ff;
   logic [HUE_BITS-1:0]   s1_frac_in, s1_frac_ff;
   logic                  s1_valid_in, s1_valid_ff;

   logic [PROD_W-1:0]     s2_prod_in, s2_prod_ff;
   logic [CH_W-1:0]       s2_hi_ff;
   logic [SECTOR_W-1:0]   s2_sector_ff;
   logic [HUE_BITS-1:0]   s2_frac_ff;
   logic                  s2_valid_in, s2_valid_ff;

   h2r_mid_type           s3_data_in, s3_data_ff;
   logic                  s3_valid_in, s3_valid_ff;

   // a stage loads when it is empty or its contents move on
   assign adv3 = !s3_valid_ff || mid_ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_bus.ready = adv1;

   // stage 1: clamp percentages, max = v*255/100, 6*hue split
   assign sat_c    = (req_bus.saturation > PCT_MAX) ? PCT_MAX : req_bus.saturation;
   assign val_c    = (req_bus.brightness > PCT_MAX) ? PCT_MAX : req_bus.brightness;
   assign val_x255 = PROD_W'({val_c, 8'b0}) - PROD_W'(val_c);
   assign hi_full  = RECIP_PW'(val_x255) * RECIP_PW'(RECIP_100);
   assign six      = (HUE_BITS+3)'({req_bus.hue, 2'b0}) + (HUE_BITS+3)'({req_bus.hue, 1'b0});

   assign s1_hi_in     = hi_full[RECIP_SHIFT +: CH_W];
   assign s1_inv_in    = PCT_MAX - sat_c;
   assign s1_sector_in = six[HUE_BITS +: SECTOR_W];
   assign s1_frac_in   = six[HUE_BITS-1:0];
   assign s1_valid_in  = adv1 ? req_bus.valid : s1_valid_ff;

   // stage 2: max*(100-s); zero saturation gives min equal to max, hence grey
   assign s2_prod_in  = PROD_W'(s1_hi_ff) * PROD_W'(s1_inv_ff);
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;

   // stage 3: divide by 100
   assign lo_full = RECIP_PW'(s2_prod_ff) * RECIP_PW'(RECIP_100);
   always_comb begin
      s3_data_in.hi     = s2_hi_ff;
      s3_data_in.lo     = lo_full[RECIP_SHIFT +: CH_W];
      s3_data_in.sector = s2_sector_ff;
      s3_data_in.frac   = s2_frac_ff;
   end
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_hi_ff     <= s1_hi_in;
         s1_inv_ff    <= s1_inv_in;
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
      end
      if (adv2) begin
         s2_prod_ff   <= s2_prod_in;
         s2_hi_ff     <= s1_hi_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_frac_ff   <= s1_frac_ff;
      end
      if (adv3) begin
         s3_data_ff   <= s3_data_in;
      end
   end

   assign mid_valid = s3_valid_ff;
   assign mid_data  = s3_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/h2r_blend.sv */
// last two stages: ramp product and six-sector channel selection
`default_nettype none

module h2r_blend (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 mid_valid,
   output logic                      mid_ready,
   input  wire h2r_pkg::h2r_mid_type mid_data,
   h2r_rsp_if.source                 rsp_bus
);
   import h2r_pkg::*;

   localparam int RP_W = HUE_BITS + CH_W;

   localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = SECTOR_W'(0);
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = SECTOR_W'(1);
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = SECTOR_W'(2);
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = SECTOR_W'(3);
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = SECTOR_W'(4);

   logic                adv4, adv5;
   logic [CH_W-1:0]     span;
   logic [RP_W-1:0]     s4_rprod_in, s4_rprod_ff;
   logic [CH_W-1:0]     s4_hi_ff, s4_lo_ff;
   logic [SECTOR_W-1:0] s4_sector_ff;
   logic                s4_valid_in, s4_valid_ff;

   logic [CH_W-1:0]     ramp, rise, fall;
   logic [CH_W-1:0]     s5_red_in, s5_green_in, s5_blue_in;
   logic [CH_W-1:0]     s5_red_ff, s5_green_ff, s5_blue_ff;
   logic                s5_valid_in, s5_valid_ff;

   assign adv5      = !s5_valid_ff || rsp_bus.ready;
   assign adv4      = !s4_valid_ff || adv5;
   assign mid_ready = adv4;

   // stage 4: frac*(max-min)
   assign span        = mid_data.hi - mid_data.lo;
   assign s4_rprod_in = RP_W'(mid_data.frac) * RP_W'(span);
   assign s4_valid_in = adv4 ? mid_valid : s4_valid_ff;

   // stage 5: pick channels by sector
   assign ramp = s4_rprod_ff[HUE_BITS +: CH_W];
   assign rise = s4_lo_ff + ramp;
   assign fall = s4_hi_ff - ramp;

   always_comb begin
      unique case (s4_sector_ff)
         SECTOR_RED_YELLOW: begin
            s5_red_in = s4_hi_ff; s5_green_in = rise;     s5_blue_in = s4_lo_ff;
         end
         SECTOR_YELLOW_GREEN: begin
            s5_red_in = fall;     s5_green_in = s4_hi_ff; s5_blue_in = s4_lo_ff;
         end
         SECTOR_GREEN_CYAN: begin
            s5_red_in = s4_lo_ff; s5_green_in = s4_hi_ff; s5_blue_in = rise;
         end
         SECTOR_CYAN_BLUE: begin
            s5_red_in = s4_lo_ff; s5_green_in = fall;     s5_blue_in = s4_hi_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            s5_red_in = rise;     s5_green_in = s4_lo_ff; s5_blue_in = s4_hi_ff;
         end
         // magenta to red sector
         default: begin
            s5_red_in = s4_hi_ff; s5_green_in = s4_lo_ff; s5_blue_in = fall;
         end
      endcase
   end
   assign s5_valid_in = adv5 ? s4_valid_ff : s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_rprod_ff  <= s4_rprod_in;
         s4_hi_ff     <= mid_data.hi;
         s4_lo_ff     <= mid_data.lo;
         s4_sector_ff <= mid_data.sector;
      end
      if (adv5) begin
         s5_red_ff   <= s5_red_in;
         s5_green_ff <= s5_green_in;
         s5_blue_ff  <= s5_blue_in;
      end
   end

   assign rsp_bus.valid = s5_valid_ff;
   assign rsp_bus.red   = s5_red_ff;
   assign rsp_bus.green = s5_green_ff;
   assign rsp_bus.blue  = s5_blue_ff;

endmodule

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter_core.sv */
// top level of the hsv to rgb converter
//
// req_bus carries hue (0.16 fraction of a turn), saturation and brightness
// (percent, values above 100 count as 100); rsp_bus returns 8-bit red, green
// and blue. Both are valid/ready channels; a transfer happens on a rising
// edge with valid and ready high.
// Five register stages: clamp and maximum channel, min product, divide by
// 100, ramp product, sector select into the output register. Each result
// passes through the stages in that order, and one item is taken every
// cycle while the receiver keeps ready high.
// Each stage holds its own valid bit and loads whenever it is empty or its
// contents move on, so bubbles close up and req_bus stays ready while a
// result waits, until all five stages are full.
// A receiver stall freezes the full stages; nothing is dropped or repeated.
// Synchronous reset empties every stage; rsp_bus.valid is low after it.
`default_nettype none
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv_to_rgb_converter_core (
   input wire logic clock,
   input wire logic reset,
   h2r_req_if.sink   req_bus,
   h2r_rsp_if.source rsp_bus
);
   import h2r_pkg::*;

   logic        mid_valid;
   logic        mid_ready;
   h2r_mid_type mid_data;

   h2r_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data)
   );

   h2r_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data),
      .rsp_bus   (rsp_bus)
   );

   // minimum channel never exceeds maximum
   `H2R_ASSERT_SAME(a_lo_le_hi, clock, reset, mid_valid, mid_data.lo <= mid_data.hi)
   // hue below a full turn keeps sector at five or less
   `H2R_ASSERT_SAME(a_sector_range, clock, reset, mid_valid, mid_data.sector <= SECTOR_W'(5))
   // held item between the halves stays put
   `H2R_ASSERT_NEXT(a_mid_hold, clock, reset, mid_valid && !mid_ready,
                    mid_valid && $stable(mid_data))

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the hsv to rgb converter core
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import h2r_pkg::*;

   localparam int TAIL_ITEMS   = 200;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_CYCLES  = 150;
   localparam int MAX_PRINTED  = 100;

   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      logic [PCT_W-1:0]    saturation;
      logic [PCT_W-1:0]    brightness;
      bit                  drain_first;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_colour_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   h2r_req_if req_bus ();
   h2r_rsp_if rsp_bus ();

   hsv_to_rgb_converter_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hsv_pixel_type  pending_pixels[$];
   rgb_colour_type expected_colours[$];
   hsv_pixel_type  on_bus;
   rgb_colour_type oldest_colour;
   int        mismatch_count = 0;
   int        transfers_sent = 0;
   int        send_gap = 0;
   int        recv_gap = 0;
   int        idle_odds = 2;
   bit        offering = 1'b0;
   bit        stall_now;
   bit        quiet_tail = 1'b0;
   bit        hold_off = 1'b0;

   always #10 clock = ~clock;

   function automatic rgb_colour_type convert_hsv(hsv_pixel_type p);
      int unsigned sat, val, peak, base, six, sector, frac, ramp;
      int unsigned r, g, b;
      rgb_colour_type c;
      sat = (p.saturation > PCT_MAX) ? 100 : int'(p.saturation);
      val = (p.brightness > PCT_MAX) ? 100 : int'(p.brightness);
      peak = (val * 255) / 100;
      if (sat == 0) begin
         r = peak;
         g = peak;
         b = peak;
      end else begin
         base = (peak * (100 - sat)) / 100;
         six = int'(p.hue) * 6;
         sector = six >> HUE_BITS;
         frac = six & ((1 << HUE_BITS) - 1);
         ramp = (frac * (peak - base)) >> HUE_BITS;
         case (sector)
            0: begin r = peak;        g = base + ramp; b = base;        end
            1: begin r = peak - ramp; g = peak;        b = base;        end
            2: begin r = base;        g = peak;        b = base + ramp; end
            3: begin r = base;        g = peak - ramp; b = peak;        end
            4: begin r = base + ramp; g = base;        b = peak;        end
            default: begin r = peak;  g = base;        b = peak - ramp; end
         endcase
      end
      c.red   = r[CH_W-1:0];
      c.green = g[CH_W-1:0];
      c.blue  = b[CH_W-1:0];
      return c;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_pixel(int hue, int sat, int val, bit drain);
      hsv_pixel_type p;
      p.hue = hue[HUE_BITS-1:0];
      p.saturation = sat[PCT_W-1:0];
      p.brightness = val[PCT_W-1:0];
      p.drain_first = drain;
      pending_pixels.push_back(p);
   endtask

   // driver: valid stays up until the transfer, gaps only between items
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         req_bus.valid <= 1'b0;
      end else begin
         if (offering && req_bus.ready) begin
            expected_colours.push_back(convert_hsv(on_bus));
            transfers_sent <= transfers_sent + 1;
            offering = 1'b0;
            if (transfers_sent % 150 == 0)
               idle_odds <= $urandom_range(0, 3);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!quiet_tail && idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
               send_gap = $urandom_range(0, 6);
            end else if (pending_pixels.size() != 0 &&
                         !(pending_pixels[0].drain_first && expected_colours.size() != 0)) begin
               on_bus = pending_pixels.pop_front();
               offering = 1'b1;
            end
         end
         quiet_tail <= pending_pixels.size() < TAIL_ITEMS;
         req_bus.valid      <= offering;
         req_bus.hue        <= on_bus.hue;
         req_bus.saturation <= on_bus.saturation;
         req_bus.brightness <= on_bus.brightness;
      end
   end

   // monitor: checks each result transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_colours.size() == 0) begin
               report_mismatch("result transfer with no colour outstanding");
            end else begin
               oldest_colour = expected_colours.pop_front();
               if (rsp_bus.red !== oldest_colour.red)
                  report_mismatch($sformatf("red %0d, expected %0d",
                                            rsp_bus.red, oldest_colour.red));
               if (rsp_bus.green !== oldest_colour.green)
                  report_mismatch($sformatf("green %0d, expected %0d",
                                            rsp_bus.green, oldest_colour.green));
               if (rsp_bus.blue !== oldest_colour.blue)
                  report_mismatch($sformatf("blue %0d, expected %0d",
                                            rsp_bus.blue, oldest_colour.blue));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            stall_now = 1'b1;
         end else if (!quiet_tail && idle_odds != 0 && $urandom_range(0, 15) < idle_odds) begin
            recv_gap = $urandom_range(0, 6);
            stall_now = 1'b1;
         end else begin
            stall_now = 1'b0;
         end
         rsp_bus.ready <= !(stall_now || hold_off);
      end
   end

   // long receiver stall so the pipeline fills and back-pressures the input
   initial begin
      wait (transfers_sent >= 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int hue, sat, val, k;
      req_bus.valid = 1'b0;
      req_bus.hue = '0;
      req_bus.saturation = '0;
      req_bus.brightness = '0;
      rsp_bus.ready = 1'b0;
      on_bus = '0;

      // extremes, grey, clamped percentages and the sector boundaries
      queue_pixel(0, 0, 0, 1'b0);
      queue_pixel(65535, 127, 127, 1'b0);
      queue_pixel(0, 100, 100, 1'b0);
      queue_pixel(65535, 100, 100, 1'b0);
      queue_pixel(12345, 0, 100, 1'b0);
      queue_pixel(40000, 0, 127, 1'b0);
      queue_pixel(20000, 101, 100, 1'b0);
      queue_pixel(50000, 127, 50, 1'b0);
      queue_pixel(30000, 60, 101, 1'b0);
      queue_pixel(8000, 1, 100, 1'b0);
      queue_pixel(10922, 100, 100, 1'b0);
      queue_pixel(10923, 100, 100, 1'b0);
      queue_pixel(21845, 100, 100, 1'b0);
      queue_pixel(21846, 100, 100, 1'b0);
      queue_pixel(32767, 100, 100, 1'b0);
      queue_pixel(32768, 100, 100, 1'b0);
      queue_pixel(43690, 100, 100, 1'b0);
      queue_pixel(43691, 100, 100, 1'b0);
      queue_pixel(54613, 100, 100, 1'b0);
      queue_pixel(54614, 75, 1, 1'b0);
      queue_pixel(43690, 50, 99, 1'b0);
      queue_pixel(21845, 99, 0, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            hue = $urandom_range(0, 65535);
         end else begin
            // near a sector edge
            k = $urandom_range(0, 6);
            hue = (k * 65536 + 5) / 6 + $urandom_range(0, 8) - 4;
            if (hue < 0) hue = 0;
            if (hue > 65535) hue = 65535;
         end
         case ($urandom_range(0, 9))
            0: sat = 0;
            1: sat = $urandom_range(101, 127);
            default: sat = $urandom_range(1, 100);
         endcase
         case ($urandom_range(0, 19))
            0: val = 0;
            1: val = $urandom_range(101, 127);
            default: val = $urandom_range(1, 100);
         endcase
         queue_pixel(hue, sat, val, i == 0 || i == RANDOM_ITEMS / 2);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_pixels.size() != 0 || offering) @(posedge clock);
      while (expected_colours.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/h2r_pkg.sv
hw/rtl/h2r_req_if.sv
hw/rtl/h2r_rsp_if.sv
hw/rtl/h2r_front.sv
hw/rtl/h2r_blend.sv
hw/rtl/hsv_to_rgb_converter_core.sv
test/tb_top.sv
